### hw/rtl/dzvd_pkg.sv
package dzvd_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned GroupW  = 7;

  // continuation flag position inside a stream byte
  localparam int unsigned MoreBit = 7;

  // number of data groups that still land (at least partly) below bit KeyW
  localparam int unsigned GroupCount = (KeyW + GroupW - 1) / GroupW;
  localparam int unsigned GrpIdxW    = $clog2(GroupCount + 1);
  localparam int unsigned ShiftW     = $clog2(KeyW);

  // one input request
  typedef struct packed {
    logic [ByteW-1:0] stream_byte;
    logic             start_of_stream;
  } dzvd_item_t;

  // one decoded record
  typedef struct packed {
    logic [KeyW-1:0] cells_used_key;
    logic [KeyW-1:0] cell_colors_key;
  } dzvd_keys_t;

  // step result handed from the decode core to the output stage
  typedef struct packed {
    logic       emit;
    dzvd_keys_t keys;
  } dzvd_step_t;

  // bit position of data group idx
  function automatic logic [ShiftW-1:0] group_shift(input logic [GrpIdxW-1:0] idx);
    logic [ShiftW+GrpIdxW-1:0] prod;
    begin
      prod = (ShiftW+GrpIdxW)'(idx) * (ShiftW+GrpIdxW)'(GroupW);
      return prod[ShiftW-1:0];
    end
  endfunction

  // zigzag to two's complement
  function automatic logic [KeyW-1:0] unzigzag(input logic [KeyW-1:0] v);
    logic [KeyW-1:0] half;
    begin
      half = v >> 1;
      return v[0] ? ~half : half;
    end
  endfunction

endpackage

### hw/rtl/dzvd_if.sv
interface dzvd_in_if import dzvd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] stream_byte;
  logic             start_of_stream;

  modport source (output valid, output stream_byte, output start_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input start_of_stream, output ready);
endinterface

interface dzvd_out_if import dzvd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] cells_used_key;
  logic [KeyW-1:0] cell_colors_key;

  modport source (output valid, output cells_used_key, output cell_colors_key, input ready);
  modport sink   (input valid, input cells_used_key, input cell_colors_key, output ready);
endinterface

### hw/rtl/dzvd_core.sv
module dzvd_core import dzvd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  dzvd_item_t item_i,
  output dzvd_step_t step_o
);

  logic [KeyW-1:0]    first_q, first_d;
  logic [KeyW-1:0]    second_q, second_d;
  logic [KeyW-1:0]    acc_q, acc_d;
  logic [GrpIdxW-1:0] grp_q, grp_d;
  logic               on_second_q, on_second_d;

  logic [KeyW-1:0]    first_base, second_base, acc_base, acc_new, delta;
  logic [GrpIdxW-1:0] grp_base, grp_new;
  logic               on_second_base;
  logic               emit;

  // one byte of decode: gather the group, finish the varint, update the predictors
  always_comb begin
    first_base     = item_i.start_of_stream ? '0 : first_q;
    second_base    = item_i.start_of_stream ? '0 : second_q;
    acc_base       = item_i.start_of_stream ? '0 : acc_q;
    grp_base       = item_i.start_of_stream ? '0 : grp_q;
    on_second_base = item_i.start_of_stream ? 1'b0 : on_second_q;

    // groups past the top of the key are dropped and the index saturates
    if (grp_base < GrpIdxW'(GroupCount)) begin
      acc_new = acc_base
              | (KeyW'(item_i.stream_byte[GroupW-1:0]) << group_shift(grp_base));
      grp_new = grp_base + GrpIdxW'(1);
    end else begin
      acc_new = acc_base;
      grp_new = grp_base;
    end

    delta       = unzigzag(acc_new);
    first_d     = first_base;
    second_d    = second_base;
    on_second_d = on_second_base;
    emit        = 1'b0;

    if (item_i.stream_byte[MoreBit]) begin
      acc_d = acc_new;
      grp_d = grp_new;
    end else begin
      acc_d = '0;
      grp_d = '0;
      if (!on_second_base) begin
        first_d     = first_base + delta;
        on_second_d = 1'b1;
      end else begin
        second_d    = second_base + delta;
        on_second_d = 1'b0;
        emit        = 1'b1;
      end
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      second_q    <= '0;
      acc_q       <= '0;
      grp_q       <= '0;
      on_second_q <= 1'b0;
    end else if (step_i) begin
      first_q     <= first_d;
      second_q    <= second_d;
      acc_q       <= acc_d;
      grp_q       <= grp_d;
      on_second_q <= on_second_d;
    end
  end

  assign step_o.emit                 = emit;
  assign step_o.keys.cells_used_key  = first_d;
  assign step_o.keys.cell_colors_key = second_d;

endmodule

### hw/rtl/delta_zigzag_varint_decoder.sv
// Delta/zigzag LEB128 record decoder: takes one stream byte per cycle, back to back, while
// the output is not stalled, and gives one record of two 64-bit keys when the second varint
// of a record ends. An accepted byte waits in the input register and is decoded from it
// (one barrel shift and OR into the varint accumulator, zigzag and one 64-bit add into a
// predictor) once the result register can take a result; a closing byte's keys go into the
// result register, which drives the output. The output register lets the next byte be taken
// while a record waits; a stall on the output stops the input after one more byte is held.
// start_of_stream clears both predictors and any partial varint before its byte is used.
module delta_zigzag_varint_decoder import dzvd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dzvd_in_if.sink     in_i,
  dzvd_out_if.source  out_o
);

  logic       in_valid_q;
  dzvd_item_t item_q;
  logic       out_valid_q;
  dzvd_keys_t keys_q;
  logic       advance;
  dzvd_step_t step;

  // the held byte moves on when the output register can take a result
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.stream_byte     <= in_i.stream_byte;
      item_q.start_of_stream <= in_i.start_of_stream;
    end
  end

  // decode step
  dzvd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .step_o (step)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step.emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step.emit) begin
      keys_q <= step.keys;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.cells_used_key  = keys_q.cells_used_key;
  assign out_o.cell_colors_key = keys_q.cell_colors_key;

  // a held byte that cannot move stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(item_q))
    else $error("held input byte lost or changed");

  // a closing byte always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step.emit |=> out_valid_q)
    else $error("record dropped");

  // a waiting record is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !advance)
    else $error("pending record overwritten");

endmodule
